[hdl/pctenc_pkg.sv]
// Shared types, register indexes and character constants of the percent-escape encoder.
package pctenc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_MAP_LOW      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MAP_MID_LOW  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAP_MID_HIGH = 3'd2;
  localparam logic [RegIdxW-1:0] REG_MAP_HIGH     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SPACE_PLUS   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_KEEP_ESC     = 3'd5;

  localparam logic [63:0] MapLowRst     = 64'hD400_002D_FFFF_FFFF;
  localparam logic [63:0] MapMidLowRst  = 64'hB800_0001_7800_0000;
  localparam logic [63:0] MapMidHighRst = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MapHighRst    = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int unsigned QueueDepth = 2;

  // Settings in force; bit v of class_map flags byte value v.
  typedef struct packed {
    logic [255:0] class_map;
    logic         space_as_plus;
    logic         keep_escapes;
  } cfg_t;

  // One classified byte: either emitted as is, or expanded to '%' and two digits.
  typedef struct packed {
    logic [7:0] data;
    logic       escape;
    logic       last;
  } job_t;

  typedef enum logic [1:0] {
    BK_FIRST,
    BK_HI,
    BK_LO
  } bk_state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

[hdl/pctenc_regs.sv]
// APB register file holding the class map and the two mode flags.
module pctenc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pctenc_pkg::AddrW-1:0]  paddr,
  input  logic [pctenc_pkg::DataW-1:0]  pwdata,
  output logic [pctenc_pkg::DataW-1:0]  prdata,
  output logic                          pready,
  output pctenc_pkg::cfg_t              cfg_o
);
  import pctenc_pkg::*;

  logic [63:0] map_low_q, map_low_d;
  logic [63:0] map_mlow_q, map_mlow_d;
  logic [63:0] map_mhigh_q, map_mhigh_d;
  logic [63:0] map_high_q, map_high_d;
  logic        plus_q, plus_d;
  logic        keep_q, keep_d;
  logic        wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[AddrW-1:AddrW-RegIdxW];

  always_comb begin
    map_low_d   = map_low_q;
    map_mlow_d  = map_mlow_q;
    map_mhigh_d = map_mhigh_q;
    map_high_d  = map_high_q;
    plus_d      = plus_q;
    keep_d      = keep_q;
    if (wr_en) begin
      case (idx)
        REG_MAP_LOW:      map_low_d   = pwdata;
        REG_MAP_MID_LOW:  map_mlow_d  = pwdata;
        REG_MAP_MID_HIGH: map_mhigh_d = pwdata;
        REG_MAP_HIGH:     map_high_d  = pwdata;
        REG_SPACE_PLUS:   plus_d      = pwdata[0];
        REG_KEEP_ESC:     keep_d      = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_low_q   <= MapLowRst;
      map_mlow_q  <= MapMidLowRst;
      map_mhigh_q <= MapMidHighRst;
      map_high_q  <= MapHighRst;
      plus_q      <= 1'b0;
      keep_q      <= 1'b0;
    end else begin
      map_low_q   <= map_low_d;
      map_mlow_q  <= map_mlow_d;
      map_mhigh_q <= map_mhigh_d;
      map_high_q  <= map_high_d;
      plus_q      <= plus_d;
      keep_q      <= keep_d;
    end
  end

  always_comb begin
    case (idx)
      REG_MAP_LOW:      prdata = map_low_q;
      REG_MAP_MID_LOW:  prdata = map_mlow_q;
      REG_MAP_MID_HIGH: prdata = map_mhigh_q;
      REG_MAP_HIGH:     prdata = map_high_q;
      REG_SPACE_PLUS:   prdata = {{(DataW-1){1'b0}}, plus_q};
      REG_KEEP_ESC:     prdata = {{(DataW-1){1'b0}}, keep_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.class_map     = {map_high_q, map_mhigh_q, map_mlow_q, map_low_q};
  assign cfg_o.space_as_plus = plus_q;
  assign cfg_o.keep_escapes  = keep_q;

endmodule

[hdl/pctenc_front.sv]
// Front end: holds the two-byte look-ahead window and classifies each byte as it leaves.
module pctenc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pctenc_pkg::cfg_t  cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pctenc_pkg::job_t  q_job_o
);
  import pctenc_pkg::*;

  logic [7:0] b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic [1:0] cnt_q, cnt_d;
  logic       flush_q, flush_d;
  logic       accept;
  logic [7:0] la2;
  logic       la_ok;
  logic       job_last;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  assign in_ready_o = !flush_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // During a flush the third window slot is the look-ahead; otherwise the new beat is.
  assign la2      = flush_q ? b2_q : in_byte_i;
  assign la_ok    = flush_q ? (cnt_q == 2'd3) : 1'b1;
  assign job_last = flush_q && (cnt_q == 2'd1);

  always_comb begin
    q_job_o.last = job_last;
    if (cfg_i.space_as_plus && b0_q == ChSpace) begin
      q_job_o.data   = ChPlus;
      q_job_o.escape = 1'b0;
    end else if (cfg_i.keep_escapes && b0_q == ChPercent && la_ok &&
                 is_hex(b1_q) && is_hex(la2)) begin
      q_job_o.data   = ChPercent;
      q_job_o.escape = 1'b0;
    end else begin
      q_job_o.data   = b0_q;
      q_job_o.escape = cfg_i.class_map[b0_q];
    end
  end

  always_comb begin
    b0_d     = b0_q;
    b1_d     = b1_q;
    b2_d     = b2_q;
    cnt_d    = cnt_q;
    flush_d  = flush_q;
    q_push_o = 1'b0;
    if (flush_q) begin
      if (!q_full_i) begin
        q_push_o = 1'b1;
        b0_d     = b1_q;
        b1_d     = b2_q;
        cnt_d    = cnt_q - 2'd1;
        if (cnt_q == 2'd1) begin
          flush_d = 1'b0;
        end
      end
    end else if (accept) begin
      if (in_last_i) begin
        case (cnt_q)
          2'd0:    b0_d = in_byte_i;
          2'd1:    b1_d = in_byte_i;
          default: b2_d = in_byte_i;
        endcase
        cnt_d   = cnt_q + 2'd1;
        flush_d = 1'b1;
      end else if (cnt_q == 2'd2) begin
        q_push_o = 1'b1;
        b0_d     = b1_q;
        b1_d     = in_byte_i;
      end else begin
        case (cnt_q)
          2'd0:    b0_d = in_byte_i;
          default: b1_d = in_byte_i;
        endcase
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      flush_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
    b2_q <= b2_d;
  end

endmodule

[hdl/pctenc_fifo.sv]
// Two-entry queue of classified bytes between the front and back ends.
module pctenc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pctenc_pkg::job_t  push_job_i,
  input  logic              pop_i,
  output pctenc_pkg::job_t  pop_job_o,
  output logic              full_o,
  output logic              empty_o
);
  import pctenc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue fill count lost a write");

endmodule

[hdl/pctenc_back.sv]
// Back end: expands queued bytes into output beats behind a registered output stage.
module pctenc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  pctenc_pkg::job_t  q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import pctenc_pkg::*;

  bk_state_e  state_q, state_d;
  logic [7:0] cur_q;
  logic       cur_last_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic       beat_valid;
  logic [7:0] beat_byte;
  logic       beat_last;

  // The output register takes a new beat when it is empty or its beat leaves now.
  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_FIRST: begin
        if (load && !q_empty_i && q_job_i.escape) begin
          state_d = BK_HI;
        end
      end
      BK_HI: begin
        if (load) begin
          state_d = BK_LO;
        end
      end
      BK_LO: begin
        if (load) begin
          state_d = BK_FIRST;
        end
      end
      default: state_d = BK_FIRST;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    beat_valid = 1'b0;
    beat_byte  = q_job_i.data;
    beat_last  = 1'b0;
    case (state_q)
      BK_FIRST: begin
        q_pop_o    = load && !q_empty_i;
        beat_valid = q_pop_o;
        beat_byte  = q_job_i.escape ? ChPercent : q_job_i.data;
        beat_last  = q_job_i.last && !q_job_i.escape;
      end
      BK_HI: begin
        beat_valid = load;
        beat_byte  = hex_char(cur_q[7:4]);
      end
      BK_LO: begin
        beat_valid = load;
        beat_byte  = hex_char(cur_q[3:0]);
        beat_last  = cur_last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= beat_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= beat_byte;
      out_last_q <= beat_last;
    end
    if (q_pop_o) begin
      cur_q      <= q_job_i.data;
      cur_last_q <= q_job_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

[hdl/percent_escape_encoder.sv]
// Top level of the percent-escape encoder: registers, front end, queue and back end.
// The encoder takes one input beat per cycle while not flushing and its queue is not
// full, and gives at most one output beat per cycle; a plain byte yields one output beat
// and an escaped byte three ('%' and two upper-case hex digits), so the output port sets
// the sustained rate. Output lags input by two bytes for the look-ahead needed by
// keep-escaped mode. On a beat marked last the front end pushes its held bytes (up to
// three) into a two-entry queue, waiting while it is full, and takes no input meanwhile.
// Held bytes are classified with the register values in force when they leave the
// window; write the registers only while the encoder is idle.
module percent_escape_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pctenc_pkg::AddrW-1:0]  paddr,
  input  logic [pctenc_pkg::DataW-1:0]  pwdata,
  output logic [pctenc_pkg::DataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o
);
  import pctenc_pkg::*;

  cfg_t cfg;
  job_t push_job;
  job_t pop_job;
  logic push, pop, full, empty;

  pctenc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pctenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_job_o    (push_job)
  );

  pctenc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .full_o     (full),
    .empty_o    (empty)
  );

  pctenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_job_i     (pop_job),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
